>>> hdl/bpd_pkg.sv
// ---------------------------------------------------------------------------
// bpd_pkg
// Shared types, constants and the pixel widening function of the bitmap
// pixel doubler.
// ---------------------------------------------------------------------------
`default_nettype none

package bpd_pkg;

  localparam int ROW_WORDS_MAX_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int WIDTH_W = 9;   // glyph_width register
  localparam int COL_W   = 5;   // byte position within a source row
  localparam int KEEP_W  = 6;   // word counts of a row, up to 32

  localparam logic [WIDTH_W-1:0] WIDTH_CAP = 9'd256;

  // configuration register indexes
  localparam logic REG_GLYPH_WIDTH = 1'b0;
  localparam logic REG_MAGNIFY_ON  = 1'b1;

  localparam logic [WORD_W-1:0] PIX_PAIR = 16'h0003;

  typedef enum logic {
    ST_IDLE,
    ST_REPEAT
  } state_t;

  // control of the line buffer cell row
  typedef struct packed {
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic              load;
    logic              shift;
  } chain_ctl_t;

  // every source pixel becomes two adjacent output pixels
  function automatic logic [WORD_W-1:0] widen(input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        w = w | (PIX_PAIR << (2 * i));
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/bpd_cell.sv
// ---------------------------------------------------------------------------
// bpd_cell
// One word of the line buffer: a stored word written at its own column and
// a readout word that is loaded from it and shifted toward the row head.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_cell #(
  parameter int INDEX = 0
) (
  input  logic                       clk,
  input  bpd_pkg::chain_ctl_t        ctl,
  input  logic [bpd_pkg::WORD_W-1:0] word_in,
  output logic [bpd_pkg::WORD_W-1:0] word_out
);
  import bpd_pkg::*;

  logic [WORD_W-1:0] stored;
  logic              hit;

  assign hit = ctl.wr_en && (int'(ctl.wr_addr) == INDEX);

  always_ff @(posedge clk) begin
    if (hit) begin
      stored <= ctl.wr_word;
    end
    // load bypasses the word written in the same cycle
    if (ctl.load) begin
      word_out <= hit ? ctl.wr_word : stored;
    end else if (ctl.shift) begin
      word_out <= word_in;
    end
  end

endmodule

`default_nettype wire

>>> hdl/bpd_row_chain.sv
// ---------------------------------------------------------------------------
// bpd_row_chain
// Row of line buffer cells; the readout words move one cell toward the
// head on every shift.
// ---------------------------------------------------------------------------
`default_nettype none

module bpd_row_chain #(
  parameter int DEPTH = bpd_pkg::ROW_WORDS_MAX_DEF
) (
  input  logic                       clk,
  input  bpd_pkg::chain_ctl_t        ctl,
  output logic [bpd_pkg::WORD_W-1:0] head
);
  import bpd_pkg::*;

  logic [WORD_W-1:0] link [DEPTH+1];

  assign link[DEPTH] = '0;
  assign head        = link[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bpd_cell #(
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .word_in  (link[i+1]),
      .word_out (link[i])
    );
  end

endmodule

`default_nettype wire

>>> hdl/bitmap_pixel_doubler_core.sv
// ---------------------------------------------------------------------------
// bitmap_pixel_doubler_core
// 2x nearest-neighbor upscale of a 1-bit glyph bitmap, one source byte per
// transfer, with a line buffer that replays each row (bytes pass through when magnify_on is clear).
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------------
//  input     in_valid / in_ready    pixel_byte
//  output    out_valid / out_ready  out_word, second_copy, run_last
//  config    cfg_write              cfg_index, cfg_data (no wait)
//
//  A byte is taken whenever the output register is free (or drains that
//  cycle). The last byte of a row starts a replay of the stored row, one
//  kept word (2 to 32, set by glyph_width) per free output slot, during
//  which no byte is taken. Output stalls hold the machine in place.
//  Reset clears the control state and the configuration registers; the
//  line buffer holds no reset value and needs no clearing pass.
//
`default_nettype none

module bitmap_pixel_doubler_core #(
  parameter int ROW_WORDS_MAX = bpd_pkg::ROW_WORDS_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [bpd_pkg::WIDTH_W-1:0] cfg_data,
  // source bytes
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bpd_pkg::BYTE_W-1:0]  pixel_byte,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpd_pkg::WORD_W-1:0]  out_word,
  output logic                        second_copy,
  output logic                        run_last
);
  import bpd_pkg::*;

  // configuration registers
  logic [WIDTH_W-1:0] glyph_width;
  logic               magnify_on;

  // control state
  state_t            state, state_next;
  logic [COL_W-1:0]  column_count, column_count_next;
  logic [KEEP_W-1:0] rep_left, rep_left_next;
  logic              out_valid_next;

  // output payload next values
  logic              out_load;
  logic [WORD_W-1:0] out_word_next;
  logic              second_copy_next;
  logic              run_last_next;

  // row geometry from the current width
  logic [WIDTH_W-1:0] eff_w;
  logic [WIDTH_W-1:0] w_up32;
  logic [WIDTH_W-1:0] w_up16;
  logic [KEEP_W-1:0]  srcb;
  logic [KEEP_W-1:0]  keep_raw;
  logic [KEEP_W-1:0]  keep;
  logic               col_kept;
  logic               last_row;

  logic              slot_free;
  logic              accept;
  logic [WORD_W-1:0] wide_word;
  logic [WORD_W-1:0] chain_head;
  chain_ctl_t        chain_ctl;

  // --- configuration ------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width <= 9'd8;
      magnify_on  <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH: glyph_width <= cfg_data;
        REG_MAGNIFY_ON:  magnify_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --- row geometry -------------------------------------------------------
  // width zero acts as one pixel, widths above 256 saturate
  always_comb begin
    eff_w = glyph_width;
    if (glyph_width == '0) begin
      eff_w = 9'd1;
    end else if (glyph_width > WIDTH_CAP) begin
      eff_w = WIDTH_CAP;
    end
  end

  // source row: whole 32-bit words; kept row: 2 words per 16 pixels
  assign w_up32   = eff_w + 9'd31;
  assign w_up16   = eff_w + 9'd15;
  assign srcb     = {w_up32[8:5], 2'b00};
  assign keep_raw = {w_up16[8:4], 1'b0};

  always_comb begin
    keep = keep_raw;
    if ({1'b0, keep_raw} > 7'(ROW_WORDS_MAX)) begin
      keep = KEEP_W'(ROW_WORDS_MAX);
    end
  end

  assign col_kept = {1'b0, column_count} < keep;
  assign last_row = ({1'b0, column_count} + 6'd1) >= srcb;

  // --- handshake ----------------------------------------------------------
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign wide_word = widen(pixel_byte);

  // --- next state and outputs ---------------------------------------------
  always_comb begin
    state_next        = state;
    column_count_next = column_count;
    rep_left_next     = rep_left;
    out_valid_next    = out_valid && !out_ready;
    out_load          = 1'b0;
    out_word_next     = wide_word;
    second_copy_next  = 1'b0;
    run_last_next     = 1'b1;

    chain_ctl.wr_en   = 1'b0;
    chain_ctl.wr_addr = column_count;
    chain_ctl.wr_word = wide_word;
    chain_ctl.load    = 1'b0;
    chain_ctl.shift   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!magnify_on) begin
            // pass-through: byte in the low half, buffer untouched
            out_load       = 1'b1;
            out_valid_next = 1'b1;
            out_word_next  = {{(WORD_W-BYTE_W){1'b0}}, pixel_byte};
          end else begin
            if (col_kept) begin
              chain_ctl.wr_en = 1'b1;
              out_load        = 1'b1;
              out_valid_next  = 1'b1;
              run_last_next   = !last_row;
            end
            if (last_row) begin
              chain_ctl.load    = 1'b1;
              rep_left_next     = keep;
              column_count_next = '0;
              state_next        = ST_REPEAT;
            end else begin
              column_count_next = column_count + 5'd1;
            end
          end
        end
      end
      ST_REPEAT: begin
        if (slot_free) begin
          // replay one stored word per free output slot
          chain_ctl.shift  = 1'b1;
          out_load         = 1'b1;
          out_valid_next   = 1'b1;
          out_word_next    = chain_head;
          second_copy_next = 1'b1;
          run_last_next    = (rep_left == 6'd1);
          rep_left_next    = rep_left - 6'd1;
          if (rep_left == 6'd1) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rep_left     <= '0;
      out_valid    <= 1'b0;
    end else begin
      column_count <= column_count_next;
      rep_left     <= rep_left_next;
      out_valid    <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word    <= out_word_next;
      second_copy <= second_copy_next;
      run_last    <= run_last_next;
    end
  end

  // --- line buffer --------------------------------------------------------
  bpd_row_chain #(
    .DEPTH (ROW_WORDS_MAX)
  ) u_row_chain (
    .clk  (clk),
    .ctl  (chain_ctl),
    .head (chain_head)
  );

  // --- checks -------------------------------------------------------------
  a_row_end_replays: assert property (@(posedge clk) disable iff (rst)
    accept && magnify_on && last_row |=> state == ST_REPEAT)
    else $error("row end did not start the replay");

  a_replay_ends: assert property (@(posedge clk) disable iff (rst)
    state == ST_REPEAT && slot_free && rep_left == 6'd1 |=>
      state == ST_IDLE && out_valid && second_copy && run_last)
    else $error("replay did not finish with a marked last word");

  a_replay_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_REPEAT |-> rep_left != '0 && !in_ready)
    else $error("replay running with no words left or taking bytes");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("pending result lost");

endmodule

`default_nettype wire
